/* sv/tgdr_pkg.sv */
// ----------------------------------------------------------------------------
// tgdr_pkg: shared types and constants for the turbine governor
// Q8.16 widths, saturation helper, micro-op codes and the config register set
// ----------------------------------------------------------------------------
package tgdr_pkg;

    // value and operand widths
    localparam int VAL_W      = 24;
    localparam int COEF_W     = 24;
    localparam int OPB_W      = 26;
    localparam int PROD_W     = COEF_W + OPB_W;
    localparam int FRAC_W     = 16;
    localparam int SAT_W      = 36;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // fixed-point constants
    localparam int Q_ONE      = 65536;
    localparam int ROUND_HALF = 32768;
    localparam int V_MAX      = 8388607;
    localparam int V_MIN      = -8388608;
    localparam int OMEGA_REF  = 65536;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(V_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(V_MIN);

    // config register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DROOP_GAIN   = 3'd0,
        REG_TORQUE_MIN   = 3'd1,
        REG_TORQUE_MAX   = 3'd2,
        REG_GOV_GAIN     = 3'd3,
        REG_SERVO_GAIN   = 3'd4,
        REG_REHEAT_GAIN  = 3'd5,
        REG_SERVO_LEAD   = 3'd6,
        REG_REHEAT_LEAD  = 3'd7
    } cfg_reg_t;

    // config register set
    typedef struct packed {
        logic        [22:0] droop_gain;
        logic signed [23:0] torque_min;
        logic signed [23:0] torque_max;
        logic        [16:0] gov_gain;
        logic        [16:0] servo_gain;
        logic        [16:0] reheat_gain;
        logic        [17:0] servo_lead_ratio;
        logic        [17:0] reheat_lead_ratio;
    } cfg_t;

    // micro-ops of the shared multiplier
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_DROOP   = 4'd1,
        OP_T2      = 4'd2,
        OP_LEADX   = 4'd3,
        OP_T3      = 4'd4,
        OP_GOV     = 4'd5,
        OP_SERVO   = 4'd6,
        OP_REHEAT  = 4'd7,
        OP_TORQ    = 4'd8,
        OP_INIT_X2 = 4'd9,
        OP_INIT_X3 = 4'd10
    } op_t;

    // sequencer to datapath control
    typedef struct packed {
        logic start;
        logic is_init;
        logic load_out;
        op_t  op;
    } ctrl_t;

    // saturate a wide signed value to the 24 bit field range
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] t;
        t = v;
        if (t > SAT_HI) begin
            t = SAT_HI;
        end
        if (t < SAT_LO) begin
            t = SAT_LO;
        end
        return t[VAL_W-1:0];
    endfunction

endpackage

/* sv/turbine_governor_droop_reheat.sv */
// ----------------------------------------------------------------------------
// turbine_governor_droop_reheat: steam turbine governor with reheat
// droop demand, clamp and three Euler lag stages on one shared multiplier
//
//  channel  dir  tdata             tuser
//  s_       in   value[23:0]       req_type (0 init, 1 step)
//  m_       out  mech_torque[23:0] demand_clamped
//  cfg_     in   write only, cfg_addr selects one of eight registers
//
//  A step word's result is raised once nine products (four on init) have run
//  one after another through the single multiplier and its product register.
//  s_tready is high only while no word is in work and rises with the result,
//  so a new word is taken only after the last one's result is loaded. A result
//  held back by m_tready stalls the next word at the end of its run. Reset is
//  synchronous, clears the state and restores the register defaults.
// ----------------------------------------------------------------------------
module turbine_governor_droop_reheat (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [23:0]                          s_tdata,   // value
    input  logic                                 s_tuser,   // req_type
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [23:0]                          m_tdata,   // mech_torque
    output logic                                 m_tuser,   // demand_clamped
    input  logic                                 cfg_wr_en,
    input  logic [tgdr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tgdr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    tgdr_pkg::cfg_t  cfg_reg, cfg_next;
    tgdr_pkg::ctrl_t ctrl;

    logic signed [tgdr_pkg::COEF_W-1:0] mul_a;
    logic signed [tgdr_pkg::OPB_W-1:0]  mul_b;
    logic signed [tgdr_pkg::VAL_W-1:0]  mul_r;
    logic signed [tgdr_pkg::VAL_W-1:0]  out_torque;
    logic                               out_clamped;

    // config register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (tgdr_pkg::cfg_reg_t'(cfg_addr))
                tgdr_pkg::REG_DROOP_GAIN:  cfg_next.droop_gain        = cfg_wdata[22:0];
                tgdr_pkg::REG_TORQUE_MIN:  cfg_next.torque_min        = cfg_wdata[23:0];
                tgdr_pkg::REG_TORQUE_MAX:  cfg_next.torque_max        = cfg_wdata[23:0];
                tgdr_pkg::REG_GOV_GAIN:    cfg_next.gov_gain          = cfg_wdata[16:0];
                tgdr_pkg::REG_SERVO_GAIN:  cfg_next.servo_gain        = cfg_wdata[16:0];
                tgdr_pkg::REG_REHEAT_GAIN: cfg_next.reheat_gain       = cfg_wdata[16:0];
                tgdr_pkg::REG_SERVO_LEAD:  cfg_next.servo_lead_ratio  = cfg_wdata[17:0];
                tgdr_pkg::REG_REHEAT_LEAD: cfg_next.reheat_lead_ratio = cfg_wdata[17:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.droop_gain        <= 23'd1310720;
            cfg_reg.torque_min        <= 24'sd0;
            cfg_reg.torque_max        <= 24'sd78643;
            cfg_reg.gov_gain          <= 17'd655;
            cfg_reg.servo_gain        <= 17'd655;
            cfg_reg.reheat_gain       <= 17'd655;
            cfg_reg.servo_lead_ratio  <= 18'd0;
            cfg_reg.reheat_lead_ratio <= 18'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer
    tgdr_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl_o   (ctrl)
    );

    // state and operand routing
    tgdr_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl_i        (ctrl),
        .cfg_i         (cfg_reg),
        .value_i       (s_tdata),
        .mul_a_o       (mul_a),
        .mul_b_o       (mul_b),
        .mul_r_i       (mul_r),
        .out_torque_o  (out_torque),
        .out_clamped_o (out_clamped)
    );

    // shared multiplier
    tgdr_mul u_mul (
        .aclk (aclk),
        .a_i  (mul_a),
        .b_i  (mul_b),
        .r_o  (mul_r)
    );

    assign m_tdata = out_torque;
    assign m_tuser = out_clamped;

endmodule

/* sv/tgdr_mul.sv */
// ----------------------------------------------------------------------------
// tgdr_mul: shared Q8.16 multiplier
// registered signed product, then round half up and saturate on the way out
// ----------------------------------------------------------------------------
module tgdr_mul (
    input  logic                                  aclk,
    input  logic signed [tgdr_pkg::COEF_W-1:0]    a_i,
    input  logic signed [tgdr_pkg::OPB_W-1:0]     b_i,
    output logic signed [tgdr_pkg::VAL_W-1:0]     r_o
);

    logic signed [tgdr_pkg::PROD_W-1:0] prod_reg;
    logic signed [tgdr_pkg::PROD_W-1:0] prod_next;
    logic signed [tgdr_pkg::PROD_W-1:0] rnd;
    logic signed [tgdr_pkg::PROD_W-tgdr_pkg::FRAC_W-1:0] shifted;

    // full product
    always_comb begin
        prod_next = tgdr_pkg::PROD_W'(a_i) * tgdr_pkg::PROD_W'(b_i);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // round half up, floor shift, saturate
    always_comb begin
        rnd     = prod_reg + tgdr_pkg::PROD_W'(tgdr_pkg::ROUND_HALF);
        shifted = rnd[tgdr_pkg::PROD_W-1:tgdr_pkg::FRAC_W];
        r_o     = tgdr_pkg::sat_val(tgdr_pkg::SAT_W'(shifted));
    end

endmodule

/* sv/tgdr_seq.sv */
// ----------------------------------------------------------------------------
// tgdr_seq: micro-op sequencer
// handshakes, step counter and the op schedule for init and step words
// ----------------------------------------------------------------------------
module tgdr_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tgdr_pkg::ctrl_t     ctrl_o
);

    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] LAST_STEP = 4'd11;
    localparam logic [CNT_W-1:0] LAST_INIT = 4'd6;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              init_reg, init_next;
    logic              mvalid_reg, mvalid_next;
    logic              accept;
    logic              last;
    logic              load;
    tgdr_pkg::op_t     op;

    // op issued at each count
    function automatic tgdr_pkg::op_t sched(input logic is_init, input logic [CNT_W-1:0] c);
        tgdr_pkg::op_t o;
        o = tgdr_pkg::OP_NONE;
        if (is_init) begin
            case (c)
                4'd0:    o = tgdr_pkg::OP_INIT_X2;
                4'd1:    o = tgdr_pkg::OP_LEADX;
                4'd3:    o = tgdr_pkg::OP_INIT_X3;
                4'd4:    o = tgdr_pkg::OP_TORQ;
                default: o = tgdr_pkg::OP_NONE;
            endcase
        end else begin
            case (c)
                4'd0:    o = tgdr_pkg::OP_DROOP;
                4'd1:    o = tgdr_pkg::OP_T2;
                4'd2:    o = tgdr_pkg::OP_LEADX;
                4'd3:    o = tgdr_pkg::OP_GOV;
                4'd4:    o = tgdr_pkg::OP_T3;
                4'd5:    o = tgdr_pkg::OP_SERVO;
                4'd6:    o = tgdr_pkg::OP_REHEAT;
                4'd7:    o = tgdr_pkg::OP_LEADX;
                4'd9:    o = tgdr_pkg::OP_TORQ;
                default: o = tgdr_pkg::OP_NONE;
            endcase
        end
        return o;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign last     = init_reg ? (cnt_reg == LAST_INIT) : (cnt_reg == LAST_STEP);
    assign m_tvalid = mvalid_reg;

    // next state and output load
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        init_next  = init_reg;
        load       = 1'b0;
        op         = tgdr_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    init_next  = ~s_tuser;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                op       = sched(init_reg, cnt_reg);
                cnt_next = cnt_reg + 1'b1;
                if (last) begin
                    if (!mvalid_reg || m_tready) begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (m_tready) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            init_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            init_reg   <= init_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // control to the datapath
    always_comb begin
        ctrl_o.start    = accept;
        ctrl_o.is_init  = ~s_tuser;
        ctrl_o.load_out = load;
        ctrl_o.op       = op;
    end

endmodule

/* sv/tgdr_datapath.sv */
// ----------------------------------------------------------------------------
// tgdr_datapath: governor state and operand routing
// feeds the shared multiplier and folds each product back into the state
// ----------------------------------------------------------------------------
module tgdr_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tgdr_pkg::ctrl_t                     ctrl_i,
    input  tgdr_pkg::cfg_t                      cfg_i,
    input  logic signed [tgdr_pkg::VAL_W-1:0]   value_i,
    output logic signed [tgdr_pkg::COEF_W-1:0]  mul_a_o,
    output logic signed [tgdr_pkg::OPB_W-1:0]   mul_b_o,
    input  logic signed [tgdr_pkg::VAL_W-1:0]   mul_r_i,
    output logic signed [tgdr_pkg::VAL_W-1:0]   out_torque_o,
    output logic                                out_clamped_o
);

    localparam int VW = tgdr_pkg::VAL_W;
    localparam int DW = tgdr_pkg::VAL_W + 1;

    typedef logic signed [VW-1:0] val_t;

    val_t v_reg, v_next;
    val_t sp_reg, sp_next;
    val_t x1_reg, x1_next;
    val_t x2_reg, x2_next;
    val_t x3_reg, x3_next;
    val_t dem_reg, dem_next;
    val_t t2_reg, t2_next;
    val_t t3_reg, t3_next;
    val_t u_reg, u_next;
    val_t tm_reg, tm_next;
    val_t otm_reg, otm_next;
    logic clamp_reg, clamp_next;
    logic oclamp_reg, oclamp_next;
    tgdr_pkg::op_t post_op_reg;

    logic signed [DW-1:0]              dem_sum;
    logic signed [tgdr_pkg::COEF_W-1:0] one_l3;
    logic signed [tgdr_pkg::COEF_W-1:0] one_l4;

    assign one_l3 = tgdr_pkg::COEF_W'(tgdr_pkg::Q_ONE)
                  - tgdr_pkg::COEF_W'({1'b0, cfg_i.servo_lead_ratio});
    assign one_l4 = tgdr_pkg::COEF_W'(tgdr_pkg::Q_ONE)
                  - tgdr_pkg::COEF_W'({1'b0, cfg_i.reheat_lead_ratio});

    // operand select for the op being issued
    always_comb begin
        mul_a_o = '0;
        mul_b_o = '0;
        case (ctrl_i.op)
            tgdr_pkg::OP_DROOP: begin
                mul_a_o = tgdr_pkg::COEF_W'({1'b0, cfg_i.droop_gain});
                mul_b_o = tgdr_pkg::OPB_W'(tgdr_pkg::OMEGA_REF) - tgdr_pkg::OPB_W'(v_reg);
            end
            tgdr_pkg::OP_T2, tgdr_pkg::OP_INIT_X2: begin
                mul_a_o = one_l3;
                mul_b_o = tgdr_pkg::OPB_W'(x1_reg);
            end
            tgdr_pkg::OP_LEADX: begin
                mul_a_o = tgdr_pkg::COEF_W'({1'b0, cfg_i.servo_lead_ratio});
                mul_b_o = tgdr_pkg::OPB_W'(x1_reg);
            end
            tgdr_pkg::OP_T3, tgdr_pkg::OP_INIT_X3: begin
                mul_a_o = one_l4;
                mul_b_o = tgdr_pkg::OPB_W'(u_reg);
            end
            tgdr_pkg::OP_GOV: begin
                mul_a_o = tgdr_pkg::COEF_W'({1'b0, cfg_i.gov_gain});
                mul_b_o = tgdr_pkg::OPB_W'(dem_reg) - tgdr_pkg::OPB_W'(x1_reg);
            end
            tgdr_pkg::OP_SERVO: begin
                mul_a_o = tgdr_pkg::COEF_W'({1'b0, cfg_i.servo_gain});
                mul_b_o = tgdr_pkg::OPB_W'(t2_reg) - tgdr_pkg::OPB_W'(x2_reg);
            end
            tgdr_pkg::OP_REHEAT: begin
                mul_a_o = tgdr_pkg::COEF_W'({1'b0, cfg_i.reheat_gain});
                mul_b_o = tgdr_pkg::OPB_W'(t3_reg) - tgdr_pkg::OPB_W'(x3_reg);
            end
            tgdr_pkg::OP_TORQ: begin
                mul_a_o = tgdr_pkg::COEF_W'({1'b0, cfg_i.reheat_lead_ratio});
                mul_b_o = tgdr_pkg::OPB_W'(u_reg);
            end
            default: begin
                mul_a_o = '0;
                mul_b_o = '0;
            end
        endcase
    end

    assign dem_sum = DW'(sp_reg) + DW'(mul_r_i);

    // write-back of the finished product, word capture and output load
    always_comb begin
        v_next      = v_reg;
        sp_next     = sp_reg;
        x1_next     = x1_reg;
        x2_next     = x2_reg;
        x3_next     = x3_reg;
        dem_next    = dem_reg;
        t2_next     = t2_reg;
        t3_next     = t3_reg;
        u_next      = u_reg;
        tm_next     = tm_reg;
        clamp_next  = clamp_reg;
        otm_next    = otm_reg;
        oclamp_next = oclamp_reg;

        if (ctrl_i.start) begin
            v_next     = value_i;
            clamp_next = 1'b0;
            if (ctrl_i.is_init) begin
                sp_next = value_i;
                x1_next = value_i;
            end
        end

        case (post_op_reg)
            tgdr_pkg::OP_DROOP: begin
                // upper limit first, lower limit wins when they cross
                dem_next = dem_sum[VW-1:0];
                if (dem_sum > DW'(cfg_i.torque_max)) begin
                    dem_next   = cfg_i.torque_max;
                    clamp_next = 1'b1;
                end
                if (DW'(dem_next) < DW'(cfg_i.torque_min) ||
                    (dem_sum < DW'(cfg_i.torque_min) &&
                     !(dem_sum > DW'(cfg_i.torque_max)))) begin
                    dem_next   = cfg_i.torque_min;
                    clamp_next = 1'b1;
                end
            end
            tgdr_pkg::OP_T2:      t2_next = mul_r_i;
            tgdr_pkg::OP_INIT_X2: x2_next = mul_r_i;
            tgdr_pkg::OP_LEADX:
                u_next = tgdr_pkg::sat_val(tgdr_pkg::SAT_W'(x2_reg) + tgdr_pkg::SAT_W'(mul_r_i));
            tgdr_pkg::OP_T3:      t3_next = mul_r_i;
            tgdr_pkg::OP_INIT_X3: x3_next = mul_r_i;
            tgdr_pkg::OP_GOV:
                x1_next = tgdr_pkg::sat_val(tgdr_pkg::SAT_W'(x1_reg) + tgdr_pkg::SAT_W'(mul_r_i));
            tgdr_pkg::OP_SERVO:
                x2_next = tgdr_pkg::sat_val(tgdr_pkg::SAT_W'(x2_reg) + tgdr_pkg::SAT_W'(mul_r_i));
            tgdr_pkg::OP_REHEAT:
                x3_next = tgdr_pkg::sat_val(tgdr_pkg::SAT_W'(x3_reg) + tgdr_pkg::SAT_W'(mul_r_i));
            tgdr_pkg::OP_TORQ:
                tm_next = tgdr_pkg::sat_val(tgdr_pkg::SAT_W'(x3_reg) + tgdr_pkg::SAT_W'(mul_r_i));
            default: begin
            end
        endcase

        if (ctrl_i.load_out) begin
            otm_next    = tm_reg;
            oclamp_next = clamp_reg;
        end
    end

    // lag states and setpoint, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            x1_reg      <= '0;
            x2_reg      <= '0;
            x3_reg      <= '0;
            post_op_reg <= tgdr_pkg::OP_NONE;
        end else begin
            sp_reg      <= sp_next;
            x1_reg      <= x1_next;
            x2_reg      <= x2_next;
            x3_reg      <= x3_next;
            post_op_reg <= ctrl_i.op;
        end
    end

    // working values and output word
    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        dem_reg    <= dem_next;
        t2_reg     <= t2_next;
        t3_reg     <= t3_next;
        u_reg      <= u_next;
        tm_reg     <= tm_next;
        clamp_reg  <= clamp_next;
        otm_reg    <= otm_next;
        oclamp_reg <= oclamp_next;
    end

    assign out_torque_o  = otm_reg;
    assign out_clamped_o = oclamp_reg;

endmodule

/* sv/tgdr_checker.sv */
// ----------------------------------------------------------------------------
// tgdr_checker: port-level checks for the turbine governor
// watches the stream handshakes over time, attached to the top level by bind
// ----------------------------------------------------------------------------
module tgdr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // one word at a time: ready drops once a word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after a word was taken");

    // a result only appears at the end of a run, never straight after a take
    a_result_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while the block was idle");

    // a stalled result word holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind turbine_governor_droop_reheat tgdr_checker u_tgdr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the turbine governor with reheat
// Drives init and step words into the input stream and programs the eight
// gain and limit registers between phases. A bit-accurate Q8.16 predictor
// keeps its own governor, servo and reheat states and queues one expected
// torque word per accepted input. Each word on the result stream is compared
// field by field with the oldest one queued. Idling on both streams is
// randomised in three phases.
// ----------------------------------------------------------------------------
module tb_top;

    // request kinds carried on s_tuser
    localparam bit REQ_INIT = 1'b0;
    localparam bit REQ_STEP = 1'b1;

    localparam int CLK_HALF   = 6;
    localparam int MAX_CYCLES = 1000000;
    localparam int MAX_PRINTS = 50;

    typedef struct {
        logic [23:0] mech_torque;
        logic        demand_clamped;
    } torque_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // value
    logic        s_tuser   = 1'b0;  // req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;           // mech_torque
    logic        m_tuser;           // demand_clamped
    logic        cfg_wr_en = 1'b0;
    logic [tgdr_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [tgdr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // register mirror, reset values of the block
    longint gp_droop  = 1310720;
    longint gp_tmin   = 0;
    longint gp_tmax   = 78643;
    longint gp_gov    = 655;
    longint gp_servo  = 655;
    longint gp_reheat = 655;
    longint gp_lead3  = 0;
    longint gp_lead4  = 0;

    // governor state mirror
    longint st_setp = 0;
    longint st_x1   = 0;
    longint st_x2   = 0;
    longint st_x3   = 0;

    torque_word_t torque_due[$];
    int           err_cnt       = 0;
    int           send_idle_pct = 33;
    int           recv_idle_pct = 86;

    always #CLK_HALF aclk = ~aclk;

    turbine_governor_droop_reheat i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Q8.16 arithmetic of the governor
    // ------------------------------------------------------------------

    function automatic longint clip24(longint v);
        if (v > tgdr_pkg::V_MAX) begin
            return tgdr_pkg::V_MAX;
        end
        if (v < tgdr_pkg::V_MIN) begin
            return tgdr_pkg::V_MIN;
        end
        return v;
    endfunction

    // product rounded half up, then saturated
    function automatic longint qmul(longint a, longint b);
        longint q;
        q = a * b + tgdr_pkg::ROUND_HALF;
        if (q >= 0) begin
            return clip24(q / 65536);
        end
        return clip24(-((-q + 65535) / 65536));
    endfunction

    function automatic longint torque_out(longint x1, longint x2, longint x3);
        longint u;
        u = clip24(x2 + qmul(gp_lead3, x1));
        return clip24(x3 + qmul(gp_lead4, u));
    endfunction

    // advance the mirrored governor by one word, return its torque word
    function automatic torque_word_t advance_governor(bit req, logic [23:0] raw);
        longint v, dem, u, t2, t3, x1, x2, x3, tm;
        torque_word_t w;
        v = longint'($signed(raw));
        w.demand_clamped = 1'b0;
        if (req == REQ_INIT) begin
            // seed all lags to steady state for this setpoint
            st_setp = v;
            st_x1   = v;
            st_x2   = qmul(tgdr_pkg::Q_ONE - gp_lead3, v);
            u       = clip24(st_x2 + qmul(gp_lead3, v));
            st_x3   = qmul(tgdr_pkg::Q_ONE - gp_lead4, u);
        end else begin
            x1  = st_x1;
            x2  = st_x2;
            x3  = st_x3;
            // droop demand, max limit first so the min limit wins
            dem = st_setp + qmul(gp_droop, tgdr_pkg::OMEGA_REF - v);
            if (dem > gp_tmax) begin
                dem = gp_tmax;
                w.demand_clamped = 1'b1;
            end
            if (dem < gp_tmin) begin
                dem = gp_tmin;
                w.demand_clamped = 1'b1;
            end
            // stage targets from the old states
            t2 = qmul(tgdr_pkg::Q_ONE - gp_lead3, x1);
            u  = clip24(x2 + qmul(gp_lead3, x1));
            t3 = qmul(tgdr_pkg::Q_ONE - gp_lead4, u);
            st_x1 = clip24(x1 + qmul(gp_gov, dem - x1));
            st_x2 = clip24(x2 + qmul(gp_servo, t2 - x2));
            st_x3 = clip24(x3 + qmul(gp_reheat, t3 - x3));
        end
        tm = torque_out(st_x1, st_x2, st_x3);
        w.mech_torque = tm[23:0];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one input word, with an optional gap before it; valid stays high after
    task automatic send_word(bit req, logic [23:0] val);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= val;
        torque_due.push_back(advance_governor(req, val));
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // stop sending and let every expected word drain
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (torque_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // one register write, enable left high for a following write
    task automatic write_reg(tgdr_pkg::cfg_reg_t r, logic [23:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= d;
        case (r)
            tgdr_pkg::REG_DROOP_GAIN:  gp_droop  = longint'(d[22:0]);
            tgdr_pkg::REG_TORQUE_MIN:  gp_tmin   = longint'($signed(d));
            tgdr_pkg::REG_TORQUE_MAX:  gp_tmax   = longint'($signed(d));
            tgdr_pkg::REG_GOV_GAIN:    gp_gov    = longint'(d[16:0]);
            tgdr_pkg::REG_SERVO_GAIN:  gp_servo  = longint'(d[16:0]);
            tgdr_pkg::REG_REHEAT_GAIN: gp_reheat = longint'(d[16:0]);
            tgdr_pkg::REG_SERVO_LEAD:  gp_lead3  = longint'(d[17:0]);
            tgdr_pkg::REG_REHEAT_LEAD: gp_lead4  = longint'(d[17:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_settings(logic [23:0] droop, logic [23:0] tmin, logic [23:0] tmax,
                                 logic [23:0] gov, logic [23:0] servo, logic [23:0] reheat,
                                 logic [23:0] lead3, logic [23:0] lead4);
        write_reg(tgdr_pkg::REG_DROOP_GAIN, droop);
        write_reg(tgdr_pkg::REG_TORQUE_MIN, tmin);
        write_reg(tgdr_pkg::REG_TORQUE_MAX, tmax);
        write_reg(tgdr_pkg::REG_GOV_GAIN, gov);
        write_reg(tgdr_pkg::REG_SERVO_GAIN, servo);
        write_reg(tgdr_pkg::REG_REHEAT_GAIN, reheat);
        write_reg(tgdr_pkg::REG_SERVO_LEAD, lead3);
        write_reg(tgdr_pkg::REG_REHEAT_LEAD, lead4);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // gain picker: zero, stated top, whole field, or a random value
    function automatic logic [23:0] pick_gain(int unsigned top, int unsigned field_max);
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'(top);
            2:       return 24'(field_max);
            3, 4:    return 24'($urandom_range(0, top));
            default: return 24'($urandom_range(0, top / 16));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        if (err_cnt < MAX_PRINTS) begin
            $display("%0t mismatch on %s: got %h want %h", $realtime, what, got, want);
        end
        err_cnt++;
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : check_torque
        torque_word_t due;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (torque_due.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 24'd0);
            end else begin
                due = torque_due.pop_front();
                if (m_tdata !== due.mech_torque) begin
                    report_mismatch("mech_torque", m_tdata, due.mech_torque);
                end
                if (m_tuser !== due.demand_clamped) begin
                    report_mismatch("demand_clamped", {23'd0, m_tuser},
                                    {23'd0, due.demand_clamped});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // steps on the reset state, default registers
    task automatic test_step_before_init();
        send_word(REQ_STEP, 24'(tgdr_pkg::OMEGA_REF));
        send_word(REQ_STEP, 24'd0);
        send_word(REQ_STEP, 24'h7FFFFF);
        send_word(REQ_STEP, 24'h800000);
    endtask

    // setpoint extremes with no lead
    task automatic test_init_extremes();
        send_word(REQ_INIT, 24'h7FFFFF);
        send_word(REQ_STEP, 24'(tgdr_pkg::OMEGA_REF));
        send_word(REQ_INIT, 24'h800000);
        send_word(REQ_STEP, 24'(tgdr_pkg::OMEGA_REF));
        send_word(REQ_INIT, 24'd0);
    endtask

    // every register at the top of its field, wide open limits
    task automatic test_register_extremes();
        quiesce();
        load_settings(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h1FFFF, 24'h1FFFF, 24'h1FFFF,
                      24'h3FFFF, 24'h3FFFF);
        send_word(REQ_INIT, 24'h7FFFFF);
        send_word(REQ_STEP, 24'h800000);
        send_word(REQ_STEP, 24'h7FFFFF);
        send_word(REQ_INIT, 24'h800000);
        send_word(REQ_STEP, 24'd0);
    endtask

    // demand exactly on a limit and 20 lsb beyond it
    task automatic test_demand_limits();
        quiesce();
        load_settings(24'(20 * tgdr_pkg::Q_ONE), 24'(-tgdr_pkg::Q_ONE), 24'(tgdr_pkg::Q_ONE),
                      24'd655, 24'd655, 24'd655,
                      24'(tgdr_pkg::Q_ONE / 4), 24'(2 * tgdr_pkg::Q_ONE));
        send_word(REQ_INIT, 24'(tgdr_pkg::Q_ONE));
        send_word(REQ_STEP, 24'(tgdr_pkg::OMEGA_REF));
        send_word(REQ_STEP, 24'(tgdr_pkg::OMEGA_REF - 1));
        send_word(REQ_INIT, 24'(-tgdr_pkg::Q_ONE));
        send_word(REQ_STEP, 24'(tgdr_pkg::OMEGA_REF));
        send_word(REQ_STEP, 24'(tgdr_pkg::OMEGA_REF + 1));
    endtask

    // min above max, zero droop: the min limit wins
    task automatic test_crossed_limits();
        quiesce();
        load_settings(24'd0, 24'(tgdr_pkg::Q_ONE / 2), 24'(-tgdr_pkg::Q_ONE / 2),
                      24'(tgdr_pkg::Q_ONE), 24'(tgdr_pkg::Q_ONE), 24'(tgdr_pkg::Q_ONE),
                      24'd0, 24'd0);
        send_word(REQ_INIT, 24'd0);
        send_word(REQ_STEP, 24'(tgdr_pkg::OMEGA_REF));
    endtask

    // runs of init plus steps near nominal speed, with some noise words
    task automatic test_random_traffic();
        int          sent;
        int          nsteps;
        int          lo;
        int          hi;
        int          dev;
        logic [23:0] setp;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 33; recv_idle_pct = 86; end
                1:       begin send_idle_pct = 86; recv_idle_pct = 33; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int blk = 0; blk < 2; blk++) begin
                quiesce();
                // limits: ordered, crossed, full range or random bits
                lo = $urandom_range(0, 8 * tgdr_pkg::Q_ONE) - 4 * tgdr_pkg::Q_ONE;
                hi = $urandom_range(0, 8 * tgdr_pkg::Q_ONE) - 4 * tgdr_pkg::Q_ONE;
                case ($urandom_range(0, 5))
                    0:       begin lo = tgdr_pkg::V_MIN; hi = tgdr_pkg::V_MAX; end
                    1:       begin lo = $urandom; hi = $urandom; end
                    2:       if (lo < hi) begin dev = lo; lo = hi; hi = dev; end
                    default: if (lo > hi) begin dev = lo; lo = hi; hi = dev; end
                endcase
                load_settings(pick_gain(4194304, 24'h7FFFFF), 24'(lo), 24'(hi),
                              pick_gain(65536, 24'h1FFFF), pick_gain(65536, 24'h1FFFF),
                              pick_gain(65536, 24'h1FFFF), pick_gain(131072, 24'h3FFFF),
                              pick_gain(131072, 24'h3FFFF));
                sent = 0;
                while (sent < 200) begin
                    if ($urandom_range(0, 9) < 8) begin
                        // well-formed run
                        if ($urandom_range(0, 9) == 0) begin
                            setp = 24'($urandom);
                        end else begin
                            setp = 24'($urandom_range(0, 3 * tgdr_pkg::Q_ONE / 2)
                                       - tgdr_pkg::Q_ONE / 4);
                        end
                        send_word(REQ_INIT, setp);
                        sent++;
                        nsteps = $urandom_range(3, 20);
                        for (int k = 0; k < nsteps; k++) begin
                            case ($urandom_range(0, 9))
                                0:       dev = $urandom;
                                1, 2:    dev = $urandom_range(0, tgdr_pkg::Q_ONE)
                                               - tgdr_pkg::Q_ONE / 2;
                                default: dev = $urandom_range(0, 8192) - 4096;
                            endcase
                            send_word(REQ_STEP, 24'(tgdr_pkg::OMEGA_REF + dev));
                            sent++;
                        end
                    end else begin
                        // noise word
                        send_word(1'($urandom_range(0, 1)), 24'($urandom));
                        sent++;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_step_before_init();
        test_init_extremes();
        test_register_extremes();
        test_demand_limits();
        test_crossed_limits();
        test_random_traffic();
        quiesce();
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #(MAX_CYCLES * 2 * CLK_HALF);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/tgdr_pkg.sv
sv/tgdr_mul.sv
sv/tgdr_seq.sv
sv/tgdr_datapath.sv
sv/turbine_governor_droop_reheat.sv
sv/tgdr_checker.sv
test/tb_top.sv
